FILE: hw/rtl/cma_pkg.sv
// shared types, constants and helpers for the counter array max tracker
package cma_pkg;

  localparam int NUM_COUNTERS = 256;
  localparam int COUNT_BITS   = 16;
  localparam int IDX_W        = $clog2(NUM_COUNTERS);
  localparam int ACT_W        = IDX_W + 1;
  localparam int CFG_W        = 9;
  localparam int HOLD_W       = 9;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [HOLD_W-1:0]     hold_t;
  typedef logic [CFG_W-1:0]      cfg_t;

  localparam logic [1:0] KIND_INC = 2'd0;
  localparam logic [1:0] KIND_DEC = 2'd1;
  localparam logic [1:0] KIND_CLR = 2'd2;

  localparam count_t TOP_VALUE = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [1:0] kind;
    idx_t       counter_index;
  } cmd_t;

  typedef struct packed {
    count_t counter_value;
    count_t max_value;
    hold_t  max_holders;
    logic   op_error;
  } res_t;

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   we;
    idx_t   wr_addr;
    count_t wr_data;
  } mem_req_t;

  // zero acts as one, anything past the array acts as the full array
  function automatic act_t clamp_active(input cfg_t value);
    act_t a;
    if (value == '0) begin
      a = act_t'(1);
    end else if (32'(value) > NUM_COUNTERS) begin
      a = act_t'(NUM_COUNTERS);
    end else begin
      a = act_t'(value);
    end
    return a;
  endfunction

endpackage

FILE: hw/rtl/cma_store.sv
// counter memory with per-entry valid bits and a registered read port
module cma_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  cma_pkg::mem_req_t req,
  output cma_pkg::count_t   rd_data
);
  import cma_pkg::*;

  count_t                  mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] valid;
  count_t                  rd_q;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

FILE: hw/rtl/cma_ctrl.sv
// command sequencer: read, modify, write back, and rescan for a lost maximum
module cma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  cma_pkg::act_t     clr_act,
  input  cma_pkg::act_t     act,
  input  logic              start,
  input  cma_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done,
  output cma_pkg::res_t     result,
  output cma_pkg::mem_req_t req,
  input  cma_pkg::count_t   rd_data
);
  import cma_pkg::*;

  typedef enum logic [1:0] {IDLE, MODIFY, SCAN} state_t;

  state_t state;
  cmd_t   cmd_q;
  count_t cur_max;
  hold_t  holders;
  act_t   scan_addr;
  logic   scan_pend;
  count_t best;
  hold_t  best_n;

  logic   in_range;
  count_t nv;
  logic   err;
  logic   need_scan;
  count_t max_next;
  hold_t  holders_next;
  logic   scan_issue;

  always_comb begin
    in_range     = act_t'(cmd_q.counter_index) < act;
    nv           = rd_data;
    err          = 1'b0;
    max_next     = cur_max;
    holders_next = holders;
    need_scan    = 1'b0;
    case (cmd_q.kind)
      KIND_INC: begin
        if (rd_data == TOP_VALUE) begin
          err = 1'b1;
        end else begin
          nv = rd_data + 1'b1;
        end
      end
      KIND_DEC: begin
        if (rd_data == '0) begin
          err = 1'b1;
        end else begin
          nv = rd_data - 1'b1;
        end
      end
      KIND_CLR: nv = '0;
      default:  err = 1'b1;
    endcase
    if (!in_range) begin
      err = 1'b1;
      nv  = '0;
    end else if (nv > rd_data) begin
      if (nv > cur_max) begin
        max_next     = nv;
        holders_next = hold_t'(1);
      end else if (nv == cur_max) begin
        holders_next = holders + 1'b1;
      end
    end else if (nv < rd_data && rd_data == cur_max) begin
      // the sole holder dropping leaves the new maximum unknown
      if (holders == hold_t'(1)) begin
        need_scan = 1'b1;
      end else begin
        holders_next = holders - 1'b1;
      end
    end
  end

  assign scan_issue = (state == SCAN) && (scan_addr < act);

  always_comb begin
    req.rd_en   = ((state == IDLE) && start) || scan_issue;
    req.rd_addr = (state == SCAN) ? scan_addr[IDX_W-1:0] : cmd.counter_index;
    req.we      = (state == MODIFY) && in_range;
    req.wr_addr = cmd_q.counter_index;
    req.wr_data = nv;
  end

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      done      <= 1'b0;
      cur_max   <= '0;
      holders   <= hold_t'(NUM_COUNTERS);
      scan_addr <= '0;
      scan_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (clr) begin
            cur_max <= '0;
            holders <= hold_t'(clr_act);
          end
          if (start) begin
            cmd_q <= cmd;
            state <= MODIFY;
          end
        end
        MODIFY: begin
          result.counter_value <= nv;
          result.op_error      <= err;
          if (need_scan) begin
            scan_addr <= '0;
            scan_pend <= 1'b0;
            best      <= '0;
            best_n    <= '0;
            state     <= SCAN;
          end else begin
            cur_max            <= max_next;
            holders            <= holders_next;
            result.max_value   <= max_next;
            result.max_holders <= holders_next;
            done               <= 1'b1;
            state              <= IDLE;
          end
        end
        SCAN: begin
          // one read issued per cycle while addresses remain, and each entry folded in when its data returns
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          scan_pend <= scan_issue;
          if (scan_pend) begin
            if (rd_data > best) begin
              best   <= rd_data;
              best_n <= hold_t'(1);
            end else if (rd_data == best) begin
              best_n <= best_n + 1'b1;
            end
          end else if (!scan_issue) begin
            cur_max            <= best;
            holders            <= best_n;
            result.max_value   <= best;
            result.max_holders <= best_n;
            done               <= 1'b1;
            state              <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/counter_array_max_tracker.sv
// top level: configuration register, sequencer and counter memory
//
// Each command is taken while busy is low; the counter is read from the memory
// and written back in the next cycle, and the result strobes on done for one
// cycle in the cycle after that, when a new command may already be taken. The
// receiver cannot stall results. When the only counter at the maximum is
// decremented or cleared, the maximum is rebuilt by reading the active counters
// through the single memory read port, one per cycle, before the result of that
// command is given. Reset and a configuration write clear the whole array at
// once through per-entry valid bits; the configuration channel is ready
// whenever no command is in flight.
module counter_array_max_tracker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cma_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output cma_pkg::res_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  cma_pkg::cfg_t cfg_data
);
  import cma_pkg::*;

  act_t     act;
  act_t     act_next;
  logic     cfg_write;
  mem_req_t req;
  count_t   rd_data;

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign act_next  = clamp_active(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= act_t'(NUM_COUNTERS);
    end else if (cfg_write) begin
      act <= act_next;
    end
  end

  cma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .clr     (cfg_write),
    .clr_act (act_next),
    .act     (act),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .req     (req),
    .rd_data (rd_data)
  );

  cma_store u_store (
    .clk     (clk),
    .rst     (rst),
    .clr     (cfg_write),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

FILE: hw/rtl/cma_checker.sv
// port-level checks for the counter array max tracker, bound to the top level
module cma_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input cma_pkg::res_t result
);
  import cma_pkg::*;

  // a taken command always occupies the block in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after a command transaction");

  // a result ends the command, so the block is free in that cycle
  a_idle_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  // no back-to-back results: every command passes through its modify step before its result strobes
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  // the named counter can never exceed the maximum, and someone holds it
  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.counter_value <= result.max_value) && (result.max_holders != '0))
    else $error("inconsistent result");

endmodule

bind counter_array_max_tracker cma_checker u_cma_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
